// ===== hw/rtl/stid_pkg.sv =====
package stid_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MISS  = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    localparam int ID_W   = 64;
    localparam int SIZE_W = 32;
    localparam int IDX_W  = 12;
    // container, size, directory mark
    localparam int PAY_W  = ID_W + SIZE_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK
    } state_t;

endpackage

// ===== hw/rtl/stid_ram.sv =====
module stid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/sorted_id_table_search.sv =====
// Append-only table of object records sorted by strictly increasing ID.
// Command channel: an item (op, object_id, container_id, size_blocks,
// is_file) is taken on a clock edge with start high and busy low.
// op add stores the record in the next free entry, op lookup binary-searches
// the stored IDs, op clear empties the table.
// Result channel: done is high for exactly one cycle with status,
// entry_index and the found fields; the receiver cannot stall it, so it must
// capture the beat in that cycle.
// Add, clear and undefined ops give done in the cycle after the command;
// busy stays low, so a command may be issued every cycle.
// Lookup: the first probe is read in the accept cycle, then S_SEARCH takes
// one step per probe (at most ceil(log2(entries+1)) steps, none for an empty
// table, 13 for a full 4096-entry table) and S_CHECK compares the candidate.
// busy is high in both states, so no new command is taken meanwhile; done is
// registered from S_CHECK and the next command can be taken while it is up.
// The single read port of the ID memory sets the pace: one probe a cycle.
// Reset empties the table (count and last ID cleared); memory contents are
// not cleared and need no clearing pass.
module sorted_id_table_search #(
    parameter int CAPACITY = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [63:0] object_id,
    input  logic [63:0] container_id,
    input  logic [31:0] size_blocks,
    input  logic        is_file,
    output logic        done,
    output logic [1:0]  status,
    output logic [11:0] entry_index,
    output logic [63:0] found_container,
    output logic [31:0] found_size,
    output logic        found_is_dir
);

    import stid_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;

    state_t state_reg, state_next;

    logic [CW-1:0]   count_reg, count_next;
    logic [ID_W-1:0] last_id_reg, last_id_next;
    logic [ID_W-1:0] key_reg, key_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]   mid_reg, mid_next;

    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [ID_W-1:0]   cont_reg, cont_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              dir_reg, dir_next;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [ID_W-1:0]   q_id;
    logic [PAY_W-1:0]  q_pay;
    logic [PAY_W-1:0]  pay_wdata;

    logic              less;
    logic [CW-1:0]     lo_a, hi_a;
    logic [CW-1:0]     mid_lo_side, mid_hi_side;
    logic [IW-1:0]     idx_count_ext, idx_lo_ext;

    stid_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_id_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (object_id),
        .rdata (q_id)
    );

    stid_ram #(
        .WIDTH (PAY_W),
        .DEPTH (CAPACITY)
    ) u_pay_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (pay_wdata),
        .rdata (q_pay)
    );

    assign pay_wdata = {container_id, size_blocks, ~is_file};

    // both candidate next probes computed up front; the compare only selects
    assign less        = q_id < key_reg;
    assign lo_a        = mid_reg + CW'(1);
    assign hi_a        = mid_reg;
    assign mid_lo_side = lo_a + ((hi_reg - lo_a) >> 1);
    assign mid_hi_side = lo_reg + ((mid_reg - lo_reg) >> 1);

    assign idx_count_ext = IW'(count_reg[AW-1:0]);
    assign idx_lo_ext    = IW'(lo_reg[AW-1:0]);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        last_id_next = last_id_reg;
        key_next     = key_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        index_next   = index_reg;
        cont_next    = cont_reg;
        size_next    = size_reg;
        dir_next     = dir_reg;
        mem_we       = 1'b0;
        mem_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    index_next  = '0;
                    cont_next   = '0;
                    size_next   = '0;
                    dir_next    = 1'b0;
                    key_next    = object_id;
                    unique case (op)
                        OP_ADD:
                        begin
                            mem_addr = count_reg[AW-1:0];
                            priority if (object_id <= last_id_reg)
                            begin
                                status_next = STAT_ORDER;
                            end
                            else if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                index_next   = idx_count_ext[IDX_W-1:0];
                                count_next   = count_reg + CW'(1);
                                last_id_next = object_id;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            done_next = 1'b0;
                            lo_next   = '0;
                            hi_next   = count_reg;
                            mid_next  = count_reg >> 1;
                            mem_addr  = mid_next[AW-1:0];
                            if (count_reg == '0)
                            begin
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            last_id_next = '0;
                        end
                        default:
                        begin
                            status_next = STAT_MISS;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (less)
                begin
                    lo_next  = lo_a;
                    mid_next = mid_lo_side;
                end
                else
                begin
                    hi_next  = hi_a;
                    mid_next = mid_hi_side;
                end
                if (lo_next < hi_next)
                begin
                    mem_addr = mid_next[AW-1:0];
                end
                else
                begin
                    // search done: fetch the candidate entry
                    mem_addr   = lo_next[AW-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if ((lo_reg < count_reg) && (q_id == key_reg))
                begin
                    status_next = STAT_OK;
                    index_next  = idx_lo_ext[IDX_W-1:0];
                    cont_next   = q_pay[PAY_W-1 -: ID_W];
                    size_next   = q_pay[SIZE_W:1];
                    dir_next    = q_pay[0];
                end
                else
                begin
                    status_next = STAT_MISS;
                    index_next  = '0;
                    cont_next   = '0;
                    size_next   = '0;
                    dir_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            last_id_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            last_id_reg <= last_id_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        cont_reg   <= cont_next;
        size_reg   <= size_next;
        dir_reg    <= dir_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign entry_index     = index_reg;
    assign found_container = cont_reg;
    assign found_size      = size_reg;
    assign found_is_dir    = dir_reg;

endmodule
